/* hdl/phong_pkg.sv */
// Shared types, constants and latencies of the Phong point light shading core.
`default_nettype none

package phong_pkg;

	// Coordinates are signed Q16.16, unit vectors and normals signed Q2.14.
	typedef logic signed [31:0] coord_t;
	typedef logic signed [15:0] unit_t;

	// Diffuse control: enable (N.L > 0) and N.L in Q16.
	typedef struct packed {
		logic        on;
		logic [18:0] ndl16;
	} diff_t;

	// Specular control: enable (R.E >= 0) and the power term in Q16.
	typedef struct packed {
		logic        on;
		logic [16:0] pow;
	} spec_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_LIGHT_X   = 3'd0,
		CFG_LIGHT_Y   = 3'd1,
		CFG_LIGHT_Z   = 3'd2,
		CFG_LIGHT_RGB = 3'd3,
		CFG_EYE_X     = 3'd4,
		CFG_EYE_Y     = 3'd5,
		CFG_EYE_Z     = 3'd6
	} cfg_idx_t;

	localparam logic [23:0] LIGHT_RGB_RESET = 24'hFFFFFF;

	// Polynomial coefficients of the log2 and exp2 approximations.
	localparam logic [15:0] LOG_K = 16'd22755;
	localparam logic [15:0] EXP_K = 16'd22487;

	// Stage counts of the pipeline sections.
	localparam int NORM_LAT  = 43;
	localparam int GEOM_LAT  = 7;
	localparam int POW_LAT   = 10;
	localparam int FRONT_LAT = 2;
	localparam int MIX_LAT   = 2;
	localparam int SPEC_AT   = NORM_LAT + GEOM_LAT + POW_LAT;
	localparam int TOTAL_LAT = SPEC_AT + MIX_LAT;

endpackage

`default_nettype wire

/* hdl/phong_dly.sv */
// Enabled delay line that keeps side data aligned with the pipeline.
`default_nettype none

module phong_dly #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign dout = tap_s[DEPTH-1];

endmodule

`default_nettype wire

/* hdl/phong_norm.sv */
// Vector normalizer: difference, range scaling, pipelined square root and division.
`default_nettype none

module phong_norm (
	input  logic              clk,
	input  logic              en,
	input  phong_pkg::coord_t pos [3],
	input  phong_pkg::coord_t hit [3],
	output phong_pkg::unit_t  dir [3]
);

	logic signed [32:0] d_s1 [3];

	logic [32:0] mag_s2 [3];
	logic [2:0]  neg_s2;
	logic [32:0] max_s2;

	logic [32:0] mag_s3 [3];
	logic [2:0]  neg_s3;
	logic [5:0]  lead_s3;
	logic        zero_s3;

	logic [19:0] sm_s4 [3];
	logic [2:0]  neg_s4;
	logic        zero_s4;

	logic [39:0] sq_s5 [3];
	logic [19:0] sm_s5 [3];
	logic [2:0]  neg_s5;
	logic        zero_s5;

	logic [41:0] sum_s6;
	logic [19:0] sm_s6 [3];
	logic [2:0]  neg_s6;
	logic        zero_s6;

	logic [32:0] mag_c [3];
	logic [32:0] max_c;
	logic [5:0]  lead_c;
	logic [32:0] shf_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = d_s1[i][32] ? 33'(-d_s1[i]) : 33'(d_s1[i]);
		end
		max_c = mag_c[0];
		if (mag_c[1] > max_c) begin
			max_c = mag_c[1];
		end
		if (mag_c[2] > max_c) begin
			max_c = mag_c[2];
		end
		lead_c = '0;
		for (int k = 0; k < 33; k++) begin
			if (max_s2[k]) begin
				lead_c = 6'(k);
			end
		end
		for (int i = 0; i < 3; i++) begin
			if (lead_s3 > 6'd19) begin
				shf_c[i] = mag_s3[i] >> (lead_s3 - 6'd19);
			end else begin
				shf_c[i] = mag_s3[i] << (6'd19 - lead_s3);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= 33'(pos[i]) - 33'(hit[i]);
				mag_s2[i] <= mag_c[i];
				neg_s2[i] <= d_s1[i][32];
				mag_s3[i] <= mag_s2[i];
				sm_s4[i] <= shf_c[i][19:0];
				sq_s5[i] <= 40'(sm_s4[i]) * 40'(sm_s4[i]);
				sm_s5[i] <= sm_s4[i];
				sm_s6[i] <= sm_s5[i];
			end
			max_s2  <= max_c;
			neg_s3  <= neg_s2;
			lead_s3 <= lead_c;
			zero_s3 <= (max_s2 == '0);
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
			sum_s6  <= 42'(sq_s5[0]) + 42'(sq_s5[1]) + 42'(sq_s5[2]);
			neg_s6  <= neg_s5;
			zero_s6 <= zero_s5;
		end
	end

	// Square root, one result bit per stage.
	logic [23:0] rt_rem_s  [22];
	logic [20:0] rt_root_s [22];
	logic [41:0] rt_val_s  [22];
	logic [19:0] rt_sm_s   [22][3];
	logic [2:0]  rt_neg_s  [22];
	logic        rt_zero_s [22];

	assign rt_rem_s[0]  = '0;
	assign rt_root_s[0] = '0;
	assign rt_val_s[0]  = sum_s6;
	assign rt_sm_s[0]   = sm_s6;
	assign rt_neg_s[0]  = neg_s6;
	assign rt_zero_s[0] = zero_s6;

	for (genvar k = 0; k < 21; k++) begin : g_sqrt
		localparam int J = 20 - k;
		logic [25:0] cur;
		logic [25:0] trial;

		assign cur   = {rt_rem_s[k], rt_val_s[k][2*J+1 -: 2]};
		assign trial = {3'b000, rt_root_s[k], 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				if (cur >= trial) begin
					rt_rem_s[k+1]  <= 24'(cur - trial);
					rt_root_s[k+1] <= {rt_root_s[k][19:0], 1'b1};
				end else begin
					rt_rem_s[k+1]  <= cur[23:0];
					rt_root_s[k+1] <= {rt_root_s[k][19:0], 1'b0};
				end
				rt_val_s[k+1]  <= rt_val_s[k];
				rt_sm_s[k+1]   <= rt_sm_s[k];
				rt_neg_s[k+1]  <= rt_neg_s[k];
				rt_zero_s[k+1] <= rt_zero_s[k];
			end
		end
	end

	// Rounded division of each scaled magnitude by the length, one quotient bit per stage.
	logic [20:0] dv_rem_s  [16][3];
	logic [14:0] dv_q_s    [16][3];
	logic [34:0] dv_num_s  [16][3];
	logic [20:0] dv_len_s  [16];
	logic [2:0]  dv_neg_s  [16];
	logic        dv_zero_s [16];

	assign dv_len_s[0]  = rt_root_s[21];
	assign dv_neg_s[0]  = rt_neg_s[21];
	assign dv_zero_s[0] = rt_zero_s[21];

	for (genvar i = 0; i < 3; i++) begin : g_div_in
		assign dv_num_s[0][i] = {1'b0, rt_sm_s[21][i], 14'b0} + 35'(rt_root_s[21] >> 1);
		assign dv_rem_s[0][i] = {1'b0, dv_num_s[0][i][34:15]};
		assign dv_q_s[0][i]   = '0;
	end

	for (genvar k = 0; k < 15; k++) begin : g_div
		localparam int B = 14 - k;
		for (genvar i = 0; i < 3; i++) begin : g_lane
			logic [21:0] cur;

			assign cur = {dv_rem_s[k][i], dv_num_s[k][i][B]};

			always_ff @(posedge clk) begin
				if (en) begin
					if (cur >= {1'b0, dv_len_s[k]}) begin
						dv_rem_s[k+1][i] <= 21'(cur - {1'b0, dv_len_s[k]});
						dv_q_s[k+1][i]   <= {dv_q_s[k][i][13:0], 1'b1};
					end else begin
						dv_rem_s[k+1][i] <= cur[20:0];
						dv_q_s[k+1][i]   <= {dv_q_s[k][i][13:0], 1'b0};
					end
					dv_num_s[k+1][i] <= dv_num_s[k][i];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_len_s[k+1]  <= dv_len_s[k];
				dv_neg_s[k+1]  <= dv_neg_s[k];
				dv_zero_s[k+1] <= dv_zero_s[k];
			end
		end
	end

	phong_pkg::unit_t dir_s [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_zero_s[15]) begin
					dir_s[i] <= '0;
				end else if (dv_neg_s[15][i]) begin
					dir_s[i] <= -$signed({1'b0, dv_q_s[15][i]});
				end else begin
					dir_s[i] <= $signed({1'b0, dv_q_s[15][i]});
				end
			end
		end
	end

	assign dir = dir_s;

endmodule

`default_nettype wire

/* hdl/phong_geom.sv */
// Dot products and reflection: N.L, R = 2(N.L)N - L, and R.E.
`default_nettype none

module phong_geom (
	input  logic               clk,
	input  logic               en,
	input  phong_pkg::unit_t   nrm [3],
	input  phong_pkg::unit_t   lv  [3],
	input  phong_pkg::unit_t   ev  [3],
	output logic signed [41:0] rde,
	output logic signed [33:0] ndl
);

	logic signed [31:0] pl_s1 [3];
	phong_pkg::unit_t   n_s1 [3], l_s1 [3], e_s1 [3];
	logic signed [33:0] ndl_s2;
	phong_pkg::unit_t   n_s2 [3], l_s2 [3], e_s2 [3];
	logic signed [19:0] ndl14_s3;
	logic signed [33:0] ndl_s3;
	phong_pkg::unit_t   n_s3 [3], l_s3 [3], e_s3 [3];
	logic signed [35:0] pr_s4 [3];
	logic signed [33:0] ndl_s4;
	phong_pkg::unit_t   l_s4 [3], e_s4 [3];
	logic signed [23:0] r_s5 [3];
	logic signed [33:0] ndl_s5;
	phong_pkg::unit_t   e_s5 [3];
	logic signed [39:0] re_s6 [3];
	logic signed [33:0] ndl_s6;
	logic signed [41:0] rde_s7;
	logic signed [33:0] ndl_s7;

	// Truncation toward zero by 2^14 works on magnitudes.
	logic [33:0]        nabs_c;
	logic signed [19:0] nq_c;
	logic [35:0]        pabs_c [3];
	logic signed [21:0] t_c [3];

	always_comb begin
		nabs_c = ndl_s2[33] ? 34'(-ndl_s2) : 34'(ndl_s2);
		nq_c   = $signed(nabs_c[33:14]);
		for (int i = 0; i < 3; i++) begin
			pabs_c[i] = pr_s4[i][35] ? 36'(-pr_s4[i]) : 36'(pr_s4[i]);
			t_c[i]    = pr_s4[i][35] ? -$signed(pabs_c[i][35:14]) : $signed(pabs_c[i][35:14]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pl_s1[i] <= nrm[i] * lv[i];
				n_s1[i]  <= nrm[i];
				l_s1[i]  <= lv[i];
				e_s1[i]  <= ev[i];
				n_s2[i]  <= n_s1[i];
				l_s2[i]  <= l_s1[i];
				e_s2[i]  <= e_s1[i];
				n_s3[i]  <= n_s2[i];
				l_s3[i]  <= l_s2[i];
				e_s3[i]  <= e_s2[i];
				pr_s4[i] <= ndl14_s3 * n_s3[i];
				l_s4[i]  <= l_s3[i];
				e_s4[i]  <= e_s3[i];
				r_s5[i]  <= (24'(t_c[i]) <<< 1) - 24'(l_s4[i]);
				e_s5[i]  <= e_s4[i];
				re_s6[i] <= r_s5[i] * e_s5[i];
			end
			ndl_s2   <= 34'(pl_s1[0]) + 34'(pl_s1[1]) + 34'(pl_s1[2]);
			ndl14_s3 <= ndl_s2[33] ? -nq_c : nq_c;
			ndl_s3   <= ndl_s2;
			ndl_s4   <= ndl_s3;
			ndl_s5   <= ndl_s4;
			ndl_s6   <= ndl_s5;
			rde_s7   <= 42'(re_s6[0]) + 42'(re_s6[1]) + 42'(re_s6[2]);
			ndl_s7   <= ndl_s6;
		end
	end

	assign rde = rde_s7;
	assign ndl = ndl_s7;

endmodule

`default_nettype wire

/* hdl/phong_pow.sv */
// Specular power (R.E)^shininess through log2 and exp2 approximations.
`default_nettype none

module phong_pow (
	input  logic               clk,
	input  logic               en,
	input  logic signed [41:0] rde,
	input  logic [15:0]        shininess,
	output phong_pkg::spec_t   spec
);

	// Flags: on = R.E >= 0, one = result forced to 1.0, zro = result forced to 0.
	logic [9:0]  on_s, one_s, zro_s;
	logic [15:0] x_s1;
	logic [15:0] sh_s1, sh_s2, sh_s3, sh_s4, sh_s5;
	logic [15:0] f_s2, f_s3;
	logic [3:0]  p_s2, p_s3, p_s4;
	logic [14:0] t_s3;
	logic [16:0] lg_s4;
	logic [20:0] a_s5;
	logic [28:0] e_s6;
	logic [12:0] ip_s7, ip_s8, ip_s9;
	logic [16:0] g_s7, g_s8;
	logic [14:0] h_s8;
	logic [17:0] mant_s9;
	logic [16:0] pow_s10;

	logic [29:0] xf_c;
	logic [16:0] x_c;
	logic [3:0]  lp_c;
	logic [31:0] sx_c;
	logic [32:0] t_prod_c;
	logic [30:0] lg_prod_c;
	logic [36:0] e_prod_c;
	logic [33:0] h_prod_c;
	logic [30:0] m_prod_c;

	always_comb begin
		xf_c = rde[41:12];
		x_c  = (xf_c > 30'd65536) ? 17'h10000 : xf_c[16:0];
		lp_c = '0;
		for (int k = 0; k < 16; k++) begin
			if (x_s1[k]) begin
				lp_c = 4'(k);
			end
		end
		sx_c      = 32'(x_s1) << (5'd16 - {1'b0, lp_c});
		t_prod_c  = 33'(f_s2) * 33'(17'h10000 - 17'(f_s2));
		lg_prod_c = 31'(t_s3) * 31'(phong_pkg::LOG_K);
		e_prod_c  = 37'(a_s5) * 37'(sh_s5);
		h_prod_c  = 34'(g_s7) * 34'(17'h10000 - g_s7);
		m_prod_c  = 31'(h_s8) * 31'(phong_pkg::EXP_K);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			on_s  <= {on_s[8:0], ~rde[41]};
			one_s <= {one_s[8:0], (shininess == '0) | x_c[16]};
			zro_s <= {zro_s[8:0], (x_c == '0)};
			x_s1  <= x_c[15:0];
			sh_s1 <= shininess;
			sh_s2 <= sh_s1;
			sh_s3 <= sh_s2;
			sh_s4 <= sh_s3;
			sh_s5 <= sh_s4;
			f_s2  <= sx_c[15:0];
			p_s2  <= lp_c;
			t_s3  <= t_prod_c[30:16];
			f_s3  <= f_s2;
			p_s3  <= p_s2;
			lg_s4 <= 17'(f_s3) + 17'(lg_prod_c[30:16]);
			p_s4  <= p_s3;
			a_s5  <= {5'd16 - {1'b0, p_s4}, 16'b0} - 21'(lg_s4);
			e_s6  <= e_prod_c[36:8];
			ip_s7 <= e_s6[28:16];
			g_s7  <= 17'h10000 - 17'(e_s6[15:0]);
			h_s8  <= h_prod_c[30:16];
			g_s8  <= g_s7;
			ip_s8 <= ip_s7;
			mant_s9 <= 18'h10000 + 18'(g_s8) - 18'(m_prod_c[30:16]);
			ip_s9   <= ip_s8;
			if (one_s[8]) begin
				pow_s10 <= 17'h10000;
			end else if (zro_s[8] || ip_s9 >= 13'd31) begin
				pow_s10 <= '0;
			end else begin
				pow_s10 <= 17'((mant_s9 >> 1) >> ip_s9[4:0]);
			end
		end
	end

	assign spec.on  = on_s[9];
	assign spec.pow = pow_s10;

endmodule

`default_nettype wire

/* hdl/phong_color.sv */
// Material and light products, then per channel mix, rounding and the output register.
`default_nettype none

module phong_color (
	input  logic             clk,
	input  logic             en,
	input  logic [23:0]      light_rgb,
	input  logic [23:0]      surface_rgb,
	input  logic [15:0]      ambient_weight,
	input  logic [15:0]      diffuse_weight,
	input  logic [15:0]      specular_weight,
	input  phong_pkg::diff_t diff,
	input  phong_pkg::spec_t spec,
	output logic [15:0]      red,
	output logic [15:0]      green,
	output logic [15:0]      blue
);

	localparam int HOLD = phong_pkg::SPEC_AT - phong_pkg::FRONT_LAT;

	logic [15:0] eff_s1 [3], l16_s1 [3];
	logic [15:0] aw_s1, dw_s1, sw_s1;
	logic [15:0] amb_s2 [3], ed_s2 [3], ls_s2 [3];
	logic [15:0] amb_d [3], ed_d [3], ls_d [3];
	logic [15:0] amb_s3 [3];
	logic [18:0] dif_s3 [3];
	logic [16:0] spc_s3 [3];
	logic [15:0] rgb_s4 [3];

	logic [7:0]  s8_c [3], l8_c [3];
	logic [31:0] eff_c [3];
	logic [31:0] amb_c [3], ed_c [3], ls_c [3];
	logic [34:0] dif_c [3];
	logic [32:0] spc_c [3];
	logic [19:0] sum_c [3];
	logic [19:0] rnd_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			s8_c[c]  = surface_rgb[23-8*c -: 8];
			l8_c[c]  = light_rgb[23-8*c -: 8];
			eff_c[c] = 32'({s8_c[c], s8_c[c]}) * 32'({l8_c[c], l8_c[c]});
			amb_c[c] = 32'(eff_s1[c]) * 32'(aw_s1);
			ed_c[c]  = 32'(eff_s1[c]) * 32'(dw_s1);
			ls_c[c]  = 32'(l16_s1[c]) * 32'(sw_s1);
			dif_c[c] = 35'(ed_d[c]) * 35'(diff.ndl16);
			spc_c[c] = 33'(ls_d[c]) * 33'(spec.pow);
			sum_c[c] = 20'(amb_s3[c]) + 20'(dif_s3[c]) + 20'(spc_s3[c]);
			// The sum stays below 2^20, so the rounded Q8.8 value never reaches saturation.
			rnd_c[c] = (sum_c[c] + 20'd128) >> 8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				eff_s1[c] <= eff_c[c][31:16];
				l16_s1[c] <= {l8_c[c], l8_c[c]};
				amb_s2[c] <= amb_c[c][31:16];
				ed_s2[c]  <= ed_c[c][31:16];
				ls_s2[c]  <= ls_c[c][31:16];
				amb_s3[c] <= amb_d[c];
				dif_s3[c] <= diff.on ? dif_c[c][34:16] : '0;
				spc_s3[c] <= spec.on ? spc_c[c][32:16] : '0;
				rgb_s4[c] <= 16'(rnd_c[c]);
			end
			aw_s1 <= ambient_weight;
			dw_s1 <= diffuse_weight;
			sw_s1 <= specular_weight;
		end
	end

	logic [143:0] hold_in, hold_out;

	assign hold_in = {amb_s2[0], amb_s2[1], amb_s2[2], ed_s2[0], ed_s2[1], ed_s2[2],
		ls_s2[0], ls_s2[1], ls_s2[2]};

	phong_dly #(
		.WIDTH(144),
		.DEPTH(HOLD)
	) u_hold (
		.clk (clk),
		.en  (en),
		.din (hold_in),
		.dout(hold_out)
	);

	assign {amb_d[0], amb_d[1], amb_d[2], ed_d[0], ed_d[1], ed_d[2],
		ls_d[0], ls_d[1], ls_d[2]} = hold_out;

	assign red   = rgb_s4[0];
	assign green = rgb_s4[1];
	assign blue  = rgb_s4[2];

endmodule

`default_nettype wire

/* hdl/phong_point_light_shading_core.sv */
// Top level of the Phong point light shading core: registers, pipeline sections, valid line.
//
//   Channel   Handshake                  Payload
//   -------   ------------------------   ----------------------------------------------
//   cfg       cfg_valid / cfg_ready      cfg_index (register 0..6), cfg_data
//   in        in_valid  / in_ready       hit_x/y/z, normal_x/y/z, surface_rgb, weights,
//                                        shininess
//   out       out_valid / out_ready      out_red, out_green, out_blue
//
// One item enters per cycle while the output is not stalled; each passes 62 register stages
// before out_valid rises. Most of that is the vector normalizer (43 stages), with
// 21 square root stages and 15 divider stages, one bit each.
// All stages advance together while the output register is empty or being taken, so a stall
// at the output freezes every item in place and in_ready follows that shared enable.
// Reset clears the valid line and loads the register reset values; the configuration
// port is always ready and its registers must only be written while no item is in flight.
`default_nettype none

module phong_point_light_shading_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] hit_x,
	input  logic [31:0] hit_y,
	input  logic [31:0] hit_z,
	input  logic [15:0] normal_x,
	input  logic [15:0] normal_y,
	input  logic [15:0] normal_z,
	input  logic [23:0] surface_rgb,
	input  logic [15:0] ambient_weight,
	input  logic [15:0] diffuse_weight,
	input  logic [15:0] specular_weight,
	input  logic [15:0] shininess,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_red,
	output logic [15:0] out_green,
	output logic [15:0] out_blue
);

	localparam int LAT = phong_pkg::TOTAL_LAT;

	// Configuration registers, written one at a time by index.
	phong_pkg::coord_t light_x_q, light_y_q, light_z_q;
	phong_pkg::coord_t eye_x_q, eye_y_q, eye_z_q;
	logic [23:0]       light_rgb_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q   <= '0;
			light_y_q   <= '0;
			light_z_q   <= '0;
			light_rgb_q <= phong_pkg::LIGHT_RGB_RESET;
			eye_x_q     <= '0;
			eye_y_q     <= '0;
			eye_z_q     <= '0;
		end else if (cfg_valid) begin
			case (phong_pkg::cfg_idx_t'(cfg_index))
				phong_pkg::CFG_LIGHT_X:   light_x_q   <= cfg_data;
				phong_pkg::CFG_LIGHT_Y:   light_y_q   <= cfg_data;
				phong_pkg::CFG_LIGHT_Z:   light_z_q   <= cfg_data;
				phong_pkg::CFG_LIGHT_RGB: light_rgb_q <= cfg_data[23:0];
				phong_pkg::CFG_EYE_X:     eye_x_q     <= cfg_data;
				phong_pkg::CFG_EYE_Y:     eye_y_q     <= cfg_data;
				phong_pkg::CFG_EYE_Z:     eye_z_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Shared stage enable: the whole pipeline moves unless a finished item is held at the output.
	logic en;
	assign en       = ~out_valid | out_ready;
	assign in_ready = en;

	// Valid bits ride alongside the data, one per stage.
	logic [LAT-1:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	assign out_valid = vld_s[LAT-1];

	// Light and eye directions are normalized in two identical units.
	phong_pkg::coord_t light_pos [3], eye_pos [3], hit_pos [3];
	phong_pkg::unit_t  lv [3], ev [3], nrm [3];

	assign light_pos = '{light_x_q, light_y_q, light_z_q};
	assign eye_pos   = '{eye_x_q, eye_y_q, eye_z_q};
	assign hit_pos   = '{hit_x, hit_y, hit_z};

	phong_norm u_norm_light (
		.clk(clk),
		.en (en),
		.pos(light_pos),
		.hit(hit_pos),
		.dir(lv)
	);

	phong_norm u_norm_eye (
		.clk(clk),
		.en (en),
		.pos(eye_pos),
		.hit(hit_pos),
		.dir(ev)
	);

	// The normal waits for the directions.
	logic [47:0] nrm_d;

	phong_dly #(
		.WIDTH(48),
		.DEPTH(phong_pkg::NORM_LAT)
	) u_nrm_dly (
		.clk (clk),
		.en  (en),
		.din ({normal_x, normal_y, normal_z}),
		.dout(nrm_d)
	);

	assign nrm = '{nrm_d[47:32], nrm_d[31:16], nrm_d[15:0]};

	logic signed [41:0] rde;
	logic signed [33:0] ndl;

	phong_geom u_geom (
		.clk(clk),
		.en (en),
		.nrm(nrm),
		.lv (lv),
		.ev (ev),
		.rde(rde),
		.ndl(ndl)
	);

	// Shininess meets R.E at the entry of the power unit.
	logic [15:0] sh_d;

	phong_dly #(
		.WIDTH(16),
		.DEPTH(phong_pkg::NORM_LAT + phong_pkg::GEOM_LAT)
	) u_sh_dly (
		.clk (clk),
		.en  (en),
		.din (shininess),
		.dout(sh_d)
	);

	phong_pkg::spec_t spec;

	phong_pow u_pow (
		.clk      (clk),
		.en       (en),
		.rde      (rde),
		.shininess(sh_d),
		.spec     (spec)
	);

	// Diffuse applies only for N.L above zero; it then waits out the power unit.
	phong_pkg::diff_t diff_c, diff_d;

	assign diff_c.on    = ~ndl[33] & (ndl != '0);
	assign diff_c.ndl16 = ndl[30:12];

	phong_dly #(
		.WIDTH($bits(phong_pkg::diff_t)),
		.DEPTH(phong_pkg::POW_LAT)
	) u_diff_dly (
		.clk (clk),
		.en  (en),
		.din (diff_c),
		.dout(diff_d)
	);

	phong_color u_color (
		.clk            (clk),
		.en             (en),
		.light_rgb      (light_rgb_q),
		.surface_rgb    (surface_rgb),
		.ambient_weight (ambient_weight),
		.diffuse_weight (diffuse_weight),
		.specular_weight(specular_weight),
		.diff           (diff_d),
		.spec           (spec),
		.red            (out_red),
		.green          (out_green),
		.blue           (out_blue)
	);

	// An accepted item shows up in the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s[0])
		else $error("accepted item missing from first stage");

	// A stalled pipeline keeps every valid bit in place.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("valid line moved during a stall");

	// Light registers change only through a configuration write.
	a_cfg_only: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_valid |=> $stable({light_x_q, light_y_q, light_z_q, light_rgb_q}))
		else $error("light register changed without a write");

	// The mixed color never exceeds the range of ambient plus diffuse plus specular.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_red[15:12] == 4'd0) && (out_green[15:12] == 4'd0)
			&& (out_blue[15:12] == 4'd0))
		else $error("output color out of range");

endmodule

`default_nettype wire

/* bench/phong_point_light_shading_core_tb.sv */
// Self-checking testbench of the Phong point light shading core: random traffic, scoreboard.
`default_nettype none

module phong_point_light_shading_core_tb;

	// One shaded color as the block delivers it.
	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} shade_t;

	// One ray hit as it is offered on the input channel.
	typedef struct packed {
		logic [31:0] hx, hy, hz;
		logic [15:0] nx, ny, nz;
		logic [23:0] rgb;
		logic [15:0] aw, dw, sw, sh;
	} hit_t;

	// The scoreboard keeps the register copy, predicts each accepted hit and checks results.
	class shade_scoreboard;
		longint lpos[3];
		longint epos[3];
		logic [23:0] lrgb;
		shade_t pending[$];
		int mismatches;

		function void reset_regs();
			lpos = '{0, 0, 0};
			epos = '{0, 0, 0};
			lrgb = phong_pkg::LIGHT_RGB_RESET;
			mismatches = 0;
		endfunction

		function void write_reg(phong_pkg::cfg_idx_t idx, logic [31:0] data);
			case (idx)
				phong_pkg::CFG_LIGHT_X:   lpos[0] = longint'($signed(data));
				phong_pkg::CFG_LIGHT_Y:   lpos[1] = longint'($signed(data));
				phong_pkg::CFG_LIGHT_Z:   lpos[2] = longint'($signed(data));
				phong_pkg::CFG_LIGHT_RGB: lrgb = data[23:0];
				phong_pkg::CFG_EYE_X:     epos[0] = longint'($signed(data));
				phong_pkg::CFG_EYE_Y:     epos[1] = longint'($signed(data));
				phong_pkg::CFG_EYE_Z:     epos[2] = longint'($signed(data));
				default: ;
			endcase
		endfunction

		static function longint trunc_shift(longint v, int k);
			if (v < 0) return -((-v) >>> k);
			return v >>> k;
		endfunction

		static function longint int_sqrt(longint unsigned v);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv >>= 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		// Direction of d as a signed Q2.14 unit vector; zero when d is zero.
		static function void direction(input longint d[3], output longint u[3]);
			longint unsigned mag[3], m, sum, len, q;
			m = 0;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				mag[i] = d[i] < 0 ? -d[i] : d[i];
				if (mag[i] > m) m = mag[i];
			end
			if (m == 0) begin
				u = '{0, 0, 0};
				return;
			end
			while (m >= (64'd1 << 20)) begin
				m >>= 1;
				for (int i = 0; i < 3; i++) mag[i] >>= 1;
			end
			while (m < (64'd1 << 19)) begin
				m <<= 1;
				for (int i = 0; i < 3; i++) mag[i] <<= 1;
			end
			for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
			len = int_sqrt(sum);
			for (int i = 0; i < 3; i++) begin
				q = ((mag[i] << 14) + len / 2) / len;
				u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
			end
		endfunction

		// (R.E)^shininess in Q16 through the log2 and exp2 approximations.
		static function longint unsigned highlight_power(longint unsigned x,
				longint unsigned sh);
			longint unsigned f, lg, e, ip, g, mant;
			int p;
			if (sh == 0) return 65536;
			if (x == 0) return 0;
			if (x >= 65536) return 65536;
			p = 0;
			while ((x >> (p + 1)) != 0) p++;
			f = (x << (16 - p)) - 65536;
			lg = f + ((((f * (65536 - f)) >> 16) * phong_pkg::LOG_K) >> 16);
			e = (((longint'(16 - p)) << 16) - lg) * sh >> 8;
			ip = e >> 16;
			g = 65536 - (e & 16'hFFFF);
			mant = 65536 + g - ((((g * (65536 - g)) >> 16) * phong_pkg::EXP_K) >> 16);
			if (ip + 1 >= 32) return 0;
			return mant >> (ip + 1);
		endfunction

		function void note_hit(hit_t h);
			longint hp[3], nv[3], dl[3], de[3], lv[3], ev[3], rv[3];
			longint ndl, ndl14, rde;
			longint unsigned powv, ndl16, x, s16, l16, eff, sum;
			logic [15:0] ch[3];
			shade_t res;
			hp = '{longint'($signed(h.hx)), longint'($signed(h.hy)), longint'($signed(h.hz))};
			nv = '{longint'($signed(h.nx)), longint'($signed(h.ny)), longint'($signed(h.nz))};
			for (int i = 0; i < 3; i++) begin
				dl[i] = lpos[i] - hp[i];
				de[i] = epos[i] - hp[i];
			end
			direction(dl, lv);
			direction(de, ev);
			ndl = 0;
			rde = 0;
			for (int i = 0; i < 3; i++) ndl += nv[i] * lv[i];
			ndl14 = trunc_shift(ndl, 14);
			for (int i = 0; i < 3; i++) rv[i] = 2 * trunc_shift(ndl14 * nv[i], 14) - lv[i];
			for (int i = 0; i < 3; i++) rde += rv[i] * ev[i];
			ndl16 = ndl > 0 ? longint'(ndl) >>> 12 : 0;
			powv = 0;
			if (rde >= 0) begin
				x = rde >>> 12;
				if (x > 65536) x = 65536;
				powv = highlight_power(x, h.sh);
			end
			for (int c = 0; c < 3; c++) begin
				s16 = ((h.rgb >> (16 - 8 * c)) & 8'hFF) * 257;
				l16 = ((lrgb >> (16 - 8 * c)) & 8'hFF) * 257;
				eff = (s16 * l16) >> 16;
				sum = (eff * h.aw) >> 16;
				if (ndl > 0) sum += (((eff * h.dw) >> 16) * ndl16) >> 16;
				if (rde >= 0) sum += (((l16 * h.sw) >> 16) * powv) >> 16;
				sum = (sum + 128) >> 8;
				if (sum > 65535) sum = 65535;
				ch[c] = sum[15:0];
			end
			res.red = ch[0];
			res.green = ch[1];
			res.blue = ch[2];
			pending.push_back(res);
		endfunction

		function void check_shade(shade_t got);
			shade_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected color %h %h %h", got.red, got.green, got.blue);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: color expected %h %h %h, got %h %h %h", want.red,
						want.green, want.blue, got.red, got.green, got.blue);
			end
		endfunction
	endclass

	localparam longint CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	hit_t        hit = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] out_red, out_green, out_blue;

	shade_scoreboard board = new();
	longint cycles = 0;
	bit hold_output = 1'b0;

	phong_point_light_shading_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.hit_x(hit.hx), .hit_y(hit.hy), .hit_z(hit.hz),
		.normal_x(hit.nx), .normal_y(hit.ny), .normal_z(hit.nz),
		.surface_rgb(hit.rgb), .ambient_weight(hit.aw), .diffuse_weight(hit.dw),
		.specular_weight(hit.sw), .shininess(hit.sh),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue)
	);

	always #2 clk = ~clk;

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Results are sampled on the rising edge that accepts them.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_shade('{out_red, out_green, out_blue});
	end

	// The receiver stalls on its own pattern: runs of ready and runs of stall, sometimes
	// a stretch of always ready, and a long hold-off whenever the stimulus asks for one.
	initial begin : receiver
		int mode, len;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(1, 40);
			repeat (len) begin
				@(negedge clk);
				if (hold_output) out_ready <= 1'b0;
				else if (mode == 0) out_ready <= 1'b1;
				else if (mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
				else if (mode == 2) out_ready <= ($urandom_range(0, 3) == 0);
				else out_ready <= 1'($urandom_range(0, 1));
			end
		end
	end

	// Registers are written only with the pipeline empty.
	task automatic write_reg(phong_pkg::cfg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Offer one hit and wait until the block has taken it. Valid is left high, so
	// back-to-back items keep it asserted without a low pulse.
	task automatic send_hit(hit_t h);
		@(negedge clk);
		in_valid <= 1'b1;
		hit <= h;
		do @(posedge clk); while (!in_ready);
		board.note_hit(h);
	endtask

	task automatic pause_input(int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Let the pipeline drain completely.
	task automatic drain();
		pause_input(0);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (phong_pkg::TOTAL_LAT + 8) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
		endcase
	endfunction

	// A random normal with one dominant axis; now and then a raw 16 bit pattern.
	function automatic hit_t rand_hit();
		hit_t h;
		int ax;
		h.hx = rand_coord();
		h.hy = rand_coord();
		h.hz = rand_coord();
		if ($urandom_range(0, 7) == 0) begin
			h.nx = 16'($urandom());
			h.ny = 16'($urandom());
			h.nz = 16'($urandom());
		end else begin
			ax = $urandom_range(0, 2);
			h.nx = 16'($signed($urandom_range(0, 16384)) - 8192);
			h.ny = 16'($signed($urandom_range(0, 16384)) - 8192);
			h.nz = 16'($signed($urandom_range(0, 16384)) - 8192);
			if (ax == 0) h.nx = $urandom_range(0, 1) ? 16'sd14000 : -16'sd14000;
			if (ax == 1) h.ny = $urandom_range(0, 1) ? 16'sd14000 : -16'sd14000;
			if (ax == 2) h.nz = $urandom_range(0, 1) ? 16'sd14000 : -16'sd14000;
		end
		h.rgb = 24'($urandom());
		h.aw = 16'($urandom());
		h.dw = 16'($urandom());
		h.sw = 16'($urandom());
		case ($urandom_range(0, 3))
			0: h.sh = 16'($urandom());
			1: h.sh = 16'h0000;
			default: h.sh = 16'($urandom_range(16'h0080, 16'h4000));
		endcase
		return h;
	endfunction

	task automatic random_phase(int n);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 30);
			repeat (burst) begin
				if (n > 0) send_hit(rand_hit());
				n--;
			end
			if ($urandom_range(0, 2) != 0) pause_input($urandom_range(1, 12));
		end
	endtask

	task automatic directed_hits();
		hit_t h;
		// With the reset register values, light and eye sit on the hit point: both unit vectors are zero.
		h = '0;
		h.rgb = 24'hFFFFFF;
		h.aw = 16'hFFFF;
		h.dw = 16'hFFFF;
		h.sw = 16'hFFFF;
		h.nz = 16'sd16384;
		send_hit(h);
		h.sh = 16'h0100;
		send_hit(h);
		// Head-on light and eye, all weights at full scale.
		h.hz = 32'shFFF00000;
		h.sh = 16'h0000;
		send_hit(h);
		h.sh = 16'hFFFF;
		send_hit(h);
		h.sh = 16'h0001;
		send_hit(h);
		// Normal facing away: no diffuse term.
		h.nz = -16'sd16384;
		send_hit(h);
		// Oversized normal and extreme normal values.
		h.nz = 16'sh7FFF;
		send_hit(h);
		h.nx = 16'sh8000;
		h.ny = 16'sh7FFF;
		h.nz = 16'sh8000;
		send_hit(h);
		// Extreme coordinates and zero material.
		h.hx = 32'h7FFFFFFF;
		h.hy = 32'h80000000;
		h.hz = 32'h7FFFFFFF;
		h.nx = 16'sd9459;
		h.ny = 16'sd9459;
		h.nz = 16'sd9459;
		send_hit(h);
		h.rgb = 24'h000000;
		h.aw = '0;
		h.dw = '0;
		h.sw = '0;
		send_hit(h);
		h.hx = 32'h80000000;
		h.hy = 32'h7FFFFFFF;
		h.rgb = 24'hFF00FF;
		h.aw = 16'h8000;
		send_hit(h);
	endtask

	initial begin : stimulus
		board.reset_regs();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset register values first, then a light and an eye on the negative z axis.
		directed_hits();
		drain();
		write_reg(phong_pkg::CFG_LIGHT_X, 32'h00000000);
		write_reg(phong_pkg::CFG_LIGHT_Y, 32'h00000000);
		write_reg(phong_pkg::CFG_LIGHT_Z, 32'hFFF00000);
		write_reg(phong_pkg::CFG_LIGHT_RGB, 32'h00FFFFFF);
		write_reg(phong_pkg::CFG_EYE_X, 32'h00000000);
		write_reg(phong_pkg::CFG_EYE_Y, 32'h00000000);
		write_reg(phong_pkg::CFG_EYE_Z, 32'hFFE00000);
		directed_hits();
		random_phase(150);

		// Long hold-off at the output while items keep coming, so input stalls.
		fork
			begin
				hold_output = 1'b1;
				repeat (phong_pkg::TOTAL_LAT * 3) @(posedge clk);
				hold_output = 1'b0;
			end
			random_phase(120);
		join
		drain();

		// Extreme register values.
		write_reg(phong_pkg::CFG_LIGHT_X, 32'h7FFFFFFF);
		write_reg(phong_pkg::CFG_LIGHT_Y, 32'h80000000);
		write_reg(phong_pkg::CFG_LIGHT_Z, 32'h7FFFFFFF);
		write_reg(phong_pkg::CFG_LIGHT_RGB, 32'h00000000);
		write_reg(phong_pkg::CFG_EYE_X, 32'h80000000);
		write_reg(phong_pkg::CFG_EYE_Y, 32'h7FFFFFFF);
		write_reg(phong_pkg::CFG_EYE_Z, 32'h80000000);
		random_phase(120);
		drain();

		// A few random settings, each with its own traffic.
		repeat (4) begin
			write_reg(phong_pkg::CFG_LIGHT_X, rand_coord());
			write_reg(phong_pkg::CFG_LIGHT_Y, rand_coord());
			write_reg(phong_pkg::CFG_LIGHT_Z, rand_coord());
			write_reg(phong_pkg::CFG_LIGHT_RGB, $urandom());
			write_reg(phong_pkg::CFG_EYE_X, rand_coord());
			write_reg(phong_pkg::CFG_EYE_Y, rand_coord());
			write_reg(phong_pkg::CFG_EYE_Z, rand_coord());
			random_phase(100);
			drain();
		end

		drain();
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
